@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion wrappers used by the timer bank RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

// check outside of reset (active-low reset)
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

@@ sv/ptb_pkg.sv @@
// ---------------------------------------------------------------------------
// ptb_pkg
// Types and constants of the PLC timer bank.
// ---------------------------------------------------------------------------
package ptb_pkg;

  localparam int TIMER_COUNT = 256;
  localparam int ID_W        = 8;
  localparam int TIME_W      = 32;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic [ID_W:0] ID_LIMIT = (ID_W + 1)'(TIMER_COUNT);

  typedef enum logic [2:0] {
    FN_ON_DELAY  = 3'd0,
    FN_OFF_DELAY = 3'd1,
    FN_PULSE     = 3'd2,
    FN_MONO      = 3'd3,
    FN_RETAIN    = 3'd4,
    FN_GET_TIME  = 3'd5,
    FN_GET_STATE = 3'd6
  } func_t;

  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] accum;
    logic              active;
    logic              on;
    logic              prev;
  } entry_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [ID_W-1:0]   tmr_id;
    logic              run_in;
    logic [TIME_W-1:0] delay_ms;
    logic              clear;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic              we;
    entry_t            ent;
    logic              on;
    logic [TIME_W-1:0] elapsed;
  } step_res_t;

endpackage

@@ sv/ptb_entry_ram.sv @@
// ---------------------------------------------------------------------------
// ptb_entry_ram
// Timer entry table: one write port, one registered read port with
// write-to-read bypass for a same-cycle update of the addressed entry.
// ---------------------------------------------------------------------------
module ptb_entry_ram (
  input  logic                  clk,
  input  logic                  we,
  input  logic [ptb_pkg::IDX_W-1:0] waddr,
  input  ptb_pkg::entry_t       wdata,
  input  logic                  re,
  input  logic [ptb_pkg::IDX_W-1:0] raddr,
  output ptb_pkg::entry_t       rdata
);
  import ptb_pkg::*;

  entry_t mem [TIMER_COUNT];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/ptb_step.sv @@
// ---------------------------------------------------------------------------
// ptb_step
// Timer update: applies one request to the current entry and forms the
// new entry and the response.
// ---------------------------------------------------------------------------
module ptb_step (
  input  ptb_pkg::req_t      req,
  input  logic               ent_vld,
  input  ptb_pkg::entry_t    ent_in,
  output ptb_pkg::step_res_t res
);
  import ptb_pkg::*;

  entry_t            e;
  entry_t            n;
  logic              in_range;
  logic [TIME_W-1:0] diff;
  logic              ge;
  logic              trig;
  logic              ge_t;
  logic              restart;
  logic [TIME_W-1:0] diff_r;
  logic [TIME_W:0]   sum;

  always_comb begin
    e        = ent_vld ? ent_in : '0;
    in_range = ({1'b0, req.tmr_id} < ID_LIMIT);
    diff     = req.now_ms - e.stamp;
    ge       = (diff >= req.delay_ms);
    trig     = req.run_in && !e.prev &&
               ((func_t'(req.func) == FN_PULSE) || !e.active);
    ge_t     = trig ? (req.delay_ms == '0) : ge;
    restart  = req.run_in && !e.prev;
    diff_r   = restart ? '0 : diff;
    sum      = {1'b0, e.accum} + {1'b0, diff_r};
    n        = e;
    res      = '0;
    if (in_range) begin
      case (func_t'(req.func))
        FN_ON_DELAY: begin
          if (req.run_in) begin
            if (!e.active) begin
              n.stamp  = req.now_ms;
              n.active = 1'b1;
              n.on     = 1'b0;
            end else if (ge) begin
              n.on = 1'b1;
            end
          end else begin
            n.active = 1'b0;
            n.on     = 1'b0;
          end
          res.we = 1'b1;
          res.on = n.on;
        end
        FN_OFF_DELAY: begin
          if (req.run_in) begin
            n.active = 1'b0;
            n.on     = 1'b1;
          end else if (e.on) begin
            if (!e.active) begin
              n.stamp  = req.now_ms;
              n.active = 1'b1;
            end else if (ge) begin
              n.on     = 1'b0;
              n.active = 1'b0;
            end
          end
          res.we = 1'b1;
          res.on = n.on;
        end
        FN_PULSE, FN_MONO: begin
          if (trig) begin
            n.stamp  = req.now_ms;
            n.active = 1'b1;
            n.on     = 1'b1;
          end
          n.prev = req.run_in;
          if (n.active) begin
            if (ge_t) begin
              n.on     = 1'b0;
              n.active = 1'b0;
            end
          end else begin
            n.on = 1'b0;
          end
          res.we = 1'b1;
          res.on = n.on;
        end
        FN_RETAIN: begin
          if (req.clear) begin
            n.accum  = '0;
            n.on     = 1'b0;
            n.active = 1'b0;
            n.prev   = req.run_in;
            res.we   = ent_vld;
            res.on   = 1'b0;
          end else begin
            if (req.run_in) begin
              if (restart) begin
                n.active = 1'b1;
              end
              n.stamp = req.now_ms;
              if (sum >= {1'b0, req.delay_ms}) begin
                n.accum = req.delay_ms;
                n.on    = 1'b1;
              end else begin
                n.accum = sum[TIME_W-1:0];
              end
            end else begin
              n.active = 1'b0;
            end
            n.prev = req.run_in;
            res.we = 1'b1;
            res.on = n.on;
          end
        end
        FN_GET_TIME: begin
          if (e.accum != '0) begin
            res.elapsed = e.accum;
          end else if (e.active) begin
            res.elapsed = diff;
          end
        end
        FN_GET_STATE: begin
          res.on = e.on;
        end
        default: begin
          res = '0;
        end
      endcase
    end
    res.ent = n;
  end

endmodule

@@ sv/plc_timer_bank_core.sv @@
// ---------------------------------------------------------------------------
// plc_timer_bank_core
// Bank of PLC timers (on-delay, off-delay, pulse, monostable, retentive)
// with time and state queries, one table entry per timer id.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one request per accepted cycle carries the function,
//   timer id, input level, preset, retentive clear and current ms time.
//   Result channel out_*: exactly one response per request, in order,
//   carrying the output level and the elapsed time.
//   Path: an accepted request is registered in the input stage, and its
//   response is captured in the output register when that stage advances.
//   Throughput: one request per cycle unless stalled; the table read is
//   issued at accept, the entry is updated and written back as the request
//   leaves the input stage; a same-id repeat takes that entry by bypass.
//   Reset: all timers read as unused immediately after reset (per-entry
//   valid flags); no clearing sweep is needed.
//   Stall: while out_stall holds a response, the one request in flight
//   waits in the input stage and in_stall rises only when both are full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module plc_timer_bank_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 in_func,
  input  logic [ptb_pkg::ID_W-1:0]   in_tmr_id,
  input  logic                       in_run_in,
  input  logic [ptb_pkg::TIME_W-1:0] in_delay_ms,
  input  logic                       in_clear,
  input  logic [ptb_pkg::TIME_W-1:0] in_now_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_on,
  output logic [ptb_pkg::TIME_W-1:0] out_elapsed_ms
);
  import ptb_pkg::*;

  logic                   s1_vld_r;
  logic                   s1_vld_nxt;
  req_t                   s1_req_r;
  logic                   out_vld_r;
  logic                   out_vld_nxt;
  logic                   out_on_r;
  logic [TIME_W-1:0]      out_elapsed_r;
  logic [TIMER_COUNT-1:0] valid_r;
  logic                   go;
  logic                   accept;
  logic                   ram_we;
  logic [IDX_W-1:0]       s1_idx;
  logic                   s1_query;
  entry_t                 rd_ent;
  step_res_t              res;

  assign go       = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !go;
  assign accept   = in_valid && !in_stall;
  assign s1_idx   = s1_req_r.tmr_id[IDX_W-1:0];
  assign ram_we   = s1_vld_r && go && res.we;
  assign s1_query = s1_vld_r && ((s1_req_r.func == FN_GET_TIME) ||
                                 (s1_req_r.func == FN_GET_STATE));

  ptb_entry_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_idx),
    .wdata (res.ent),
    .re    (accept),
    .raddr (in_tmr_id[IDX_W-1:0]),
    .rdata (rd_ent)
  );

  ptb_step u_step (
    .req     (s1_req_r),
    .ent_vld (valid_r[s1_idx]),
    .ent_in  (rd_ent),
    .res     (res)
  );

  always_comb begin
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (go) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
    if (s1_vld_r && go) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      valid_r   <= '0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (ram_we) begin
        valid_r[s1_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req_r.func     <= in_func;
      s1_req_r.tmr_id   <= in_tmr_id;
      s1_req_r.run_in   <= in_run_in;
      s1_req_r.delay_ms <= in_delay_ms;
      s1_req_r.clear    <= in_clear;
      s1_req_r.now_ms   <= in_now_ms;
    end
    if (s1_vld_r && go) begin
      out_on_r      <= res.on;
      out_elapsed_r <= res.elapsed;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_on         = out_on_r;
  assign out_elapsed_ms = out_elapsed_r;

  `ASSERT_ALWAYS(a_reset_clears_valid, clk, !rst_n |=> (valid_r == '0), "valid not cleared")
  `ASSERT_RST(a_stall_needs_busy, clk, rst_n, in_stall |-> (s1_vld_r && out_vld_r), "bad stall")
  `ASSERT_RST(a_write_on_advance, clk, rst_n, ram_we |-> (s1_vld_r && go), "write w/o advance")
  `ASSERT_RST(a_query_no_write, clk, rst_n, s1_query |-> !ram_we, "query wrote table")

endmodule

@@ tb/sv/tb_plc_timer_bank_core.sv @@
// ---------------------------------------------------------------------------
// tb_plc_timer_bank_core
// Self-checking bench for the PLC timer bank. Requests are sent over the
// valid/stall input channel and predicted at accept by a local copy of the
// timer table. Each response is compared with the oldest prediction. The
// run covers directed timer scenarios, random timer scan sequences mixed
// with noise requests under several idle and stall mixes, and a long
// output hold-off that backs up the input.
// ---------------------------------------------------------------------------
module tb_plc_timer_bank_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ptb_pkg::*;

  localparam logic [2:0] FN_RESERVED = 3'd7;
  localparam int HOLD_LEN    = 300;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [2:0]        fn;
    logic [ID_W-1:0]   id;
    logic              on;
    logic [TIME_W-1:0] elapsed;
  } timer_resp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_func = '0;
  logic [ID_W-1:0]   in_tmr_id = '0;
  logic              in_run_in = 1'b0;
  logic [TIME_W-1:0] in_delay_ms = '0;
  logic              in_clear = 1'b0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_on;
  logic [TIME_W-1:0] out_elapsed_ms;

  bit [TIME_W-1:0] t_stamp  [TIMER_COUNT];
  bit [TIME_W-1:0] t_accum  [TIMER_COUNT];
  bit              t_used   [TIMER_COUNT];
  bit              t_active [TIMER_COUNT];
  bit              t_on     [TIMER_COUNT];
  bit              t_prev   [TIMER_COUNT];

  timer_resp_t pending_resp[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;

  plc_timer_bank_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_tmr_id      (in_tmr_id),
    .in_run_in      (in_run_in),
    .in_delay_ms    (in_delay_ms),
    .in_clear       (in_clear),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_on         (out_on),
    .out_elapsed_ms (out_elapsed_ms)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void claim_timer(logic [ID_W-1:0] id);
    if (!t_used[id]) begin
      t_stamp[id]  = '0;
      t_accum[id]  = '0;
      t_active[id] = 1'b0;
      t_on[id]     = 1'b0;
      t_prev[id]   = 1'b0;
      t_used[id]   = 1'b1;
    end
  endfunction

  function automatic timer_resp_t step_timer(logic [2:0] fn, logic [ID_W-1:0] id, logic run,
                                             logic [TIME_W-1:0] delay, logic clr,
                                             logic [TIME_W-1:0] now);
    timer_resp_t r;
    logic [TIME_W-1:0] span;
    logic [TIME_W:0]   total;
    r.fn = fn;
    r.id = id;
    r.on = 1'b0;
    r.elapsed = '0;
    if (int'(id) >= TIMER_COUNT) return r;
    span = now - t_stamp[id];
    case (fn)
      FN_ON_DELAY: begin
        claim_timer(id);
        span = now - t_stamp[id];
        if (run) begin
          if (!t_active[id]) begin
            t_stamp[id]  = now;
            t_active[id] = 1'b1;
            t_on[id]     = 1'b0;
          end else if (span >= delay) begin
            t_on[id] = 1'b1;
          end
        end else begin
          t_active[id] = 1'b0;
          t_on[id]     = 1'b0;
        end
        r.on = t_on[id];
      end
      FN_OFF_DELAY: begin
        claim_timer(id);
        span = now - t_stamp[id];
        if (run) begin
          t_active[id] = 1'b0;
          t_on[id]     = 1'b1;
        end else if (t_on[id]) begin
          if (!t_active[id]) begin
            t_stamp[id]  = now;
            t_active[id] = 1'b1;
          end else if (span >= delay) begin
            t_on[id]     = 1'b0;
            t_active[id] = 1'b0;
          end
        end
        r.on = t_on[id];
      end
      FN_PULSE, FN_MONO: begin
        claim_timer(id);
        if (run && !t_prev[id] && (fn == FN_PULSE || !t_active[id])) begin
          t_stamp[id]  = now;
          t_active[id] = 1'b1;
          t_on[id]     = 1'b1;
        end
        t_prev[id] = run;
        span = now - t_stamp[id];
        if (t_active[id]) begin
          if (span >= delay) begin
            t_on[id]     = 1'b0;
            t_active[id] = 1'b0;
          end
        end else begin
          t_on[id] = 1'b0;
        end
        r.on = t_on[id];
      end
      FN_RETAIN: begin
        if (clr) begin
          if (t_used[id]) begin
            t_accum[id]  = '0;
            t_on[id]     = 1'b0;
            t_active[id] = 1'b0;
            t_prev[id]   = run;
          end
        end else begin
          claim_timer(id);
          if (run) begin
            if (!t_prev[id]) begin
              t_stamp[id]  = now;
              t_active[id] = 1'b1;
            end
            span  = now - t_stamp[id];
            total = {1'b0, t_accum[id]} + {1'b0, span};
            t_stamp[id] = now;
            if (total >= {1'b0, delay}) begin
              t_accum[id] = delay;
              t_on[id]    = 1'b1;
            end else begin
              t_accum[id] = total[TIME_W-1:0];
            end
          end else begin
            t_active[id] = 1'b0;
          end
          t_prev[id] = run;
          r.on = t_on[id];
        end
      end
      FN_GET_TIME: begin
        if (t_used[id]) begin
          if (t_accum[id] != '0) r.elapsed = t_accum[id];
          else if (t_active[id]) r.elapsed = span;
        end
      end
      FN_GET_STATE: begin
        if (t_used[id]) r.on = t_on[id];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_req(input logic [2:0] fn, input logic [ID_W-1:0] id, input logic run,
                          input logic [TIME_W-1:0] delay, input logic clr,
                          input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= fn;
    in_tmr_id   <= id;
    in_run_in   <= run;
    in_delay_ms <= delay;
    in_clear    <= clr;
    in_now_ms   <= now;
    do @(posedge clk); while (in_stall !== 1'b0);
    pending_resp.push_back(step_timer(fn, id, run, delay, clr, now));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_req(FN_ON_DELAY, 8'd0, 1'b1, 32'd50, 1'b0, 32'd100);
    send_req(FN_ON_DELAY, 8'd0, 1'b1, 32'd50, 1'b0, 32'd149);
    send_req(FN_ON_DELAY, 8'd0, 1'b1, 32'd50, 1'b0, 32'd150);
    send_req(FN_GET_TIME, 8'd0, 1'b0, 32'd0, 1'b0, 32'd170);
    send_req(FN_GET_STATE, 8'd0, 1'b0, 32'd0, 1'b0, 32'd170);
    send_req(FN_ON_DELAY, 8'd0, 1'b0, 32'd50, 1'b0, 32'd180);
    send_req(FN_OFF_DELAY, 8'hFF, 1'b1, 32'd20, 1'b0, 32'd200);
    send_req(FN_OFF_DELAY, 8'hFF, 1'b0, 32'd20, 1'b0, 32'd210);
    send_req(FN_OFF_DELAY, 8'hFF, 1'b0, 32'd20, 1'b0, 32'd230);
    send_req(FN_PULSE, 8'd1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFF0);
    send_req(FN_PULSE, 8'd1, 1'b0, 32'hFFFF_FFFF, 1'b0, 32'h0000_0010);
    send_req(FN_GET_TIME, 8'd1, 1'b0, 32'd0, 1'b0, 32'h0000_0020);
    send_req(FN_MONO, 8'd2, 1'b1, 32'd0, 1'b0, 32'd5);
    send_req(FN_RETAIN, 8'd3, 1'b1, 32'd100, 1'b0, 32'd1000);
    send_req(FN_RETAIN, 8'd3, 1'b1, 32'd100, 1'b0, 32'd1060);
    send_req(FN_RETAIN, 8'd3, 1'b0, 32'd100, 1'b0, 32'd1100);
    send_req(FN_RETAIN, 8'd3, 1'b1, 32'd100, 1'b0, 32'd2000);
    send_req(FN_RETAIN, 8'd3, 1'b1, 32'd100, 1'b0, 32'd2050);
    send_req(FN_GET_TIME, 8'd3, 1'b0, 32'd0, 1'b0, 32'd2060);
    send_req(FN_RETAIN, 8'd3, 1'b1, 32'd100, 1'b1, 32'd2070);
    send_req(FN_GET_STATE, 8'd3, 1'b0, 32'd0, 1'b0, 32'd2080);
    send_req(FN_RETAIN, 8'd17, 1'b1, 32'd100, 1'b1, 32'd2090);
    send_req(FN_GET_TIME, 8'd200, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_req(FN_GET_STATE, 8'd200, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_req(FN_RESERVED, 8'd0, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    wait_drain();
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
    logic [ID_W-1:0]   slot_id    [8];
    logic [2:0]        slot_fn    [8];
    logic [TIME_W-1:0] slot_delay [8];
    logic              slot_level [8];
    logic [TIME_W-1:0] clock_ms;
    logic [2:0]        fn;
    logic [ID_W-1:0]   id;
    logic              run;
    logic              clr;
    logic [TIME_W-1:0] delay;
    logic [TIME_W-1:0] now;
    int                s;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < 8; k++) begin
      slot_id[k]    = (k == 0) ? 8'd0 : (k == 1) ? 8'hFF : 8'($urandom_range(255));
      slot_fn[k]    = 3'($urandom_range(4));
      slot_delay[k] = $urandom_range(120);
      slot_level[k] = 1'($urandom_range(1));
    end
    clock_ms = $urandom;
    repeat (n_items) begin
      if ($urandom_range(99) < 85) begin
        s  = $urandom_range(7);
        id = slot_id[s];
        fn = ($urandom_range(2) == 0) ? 3'($urandom_range(6)) : slot_fn[s];
        if ($urandom_range(3) == 0) slot_level[s] = ~slot_level[s];
        run   = slot_level[s];
        clr   = (fn == FN_RETAIN) && ($urandom_range(7) == 0);
        delay = ($urandom_range(4) == 0) ? 32'($urandom_range(120)) : slot_delay[s];
        if ($urandom_range(19) == 0) delay = $urandom;
        clock_ms += $urandom_range(30);
        now = clock_ms;
      end else begin
        fn    = 3'($urandom);
        id    = 8'($urandom);
        run   = 1'($urandom);
        clr   = 1'($urandom);
        delay = $urandom;
        now   = $urandom;
      end
      send_req(fn, id, run, delay, clr, now);
    end
    wait_drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_seq++;
    for (int k = 0; k < 40; k++) begin
      send_req(3'(k % 7), 8'(k % 5), 1'(k / 3 % 2), 32'(k % 11), 1'(k % 9 == 0), 32'(k * 13));
    end
    wait_drain();
  endtask

  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    timer_resp_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (pending_resp.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected response: on %0b elapsed %0d", out_on, out_elapsed_ms);
          mismatches++;
        end else begin
          exp_r = pending_resp.pop_front();
          if (out_on !== exp_r.on || out_elapsed_ms !== exp_r.elapsed) begin
            if (mismatches < 10)
              $display("mismatch fn %0d id %0d: exp on %0b el %0d, got on %0b el %0d",
                       exp_r.fn, exp_r.id, exp_r.on, exp_r.elapsed, out_on, out_elapsed_ms);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_plc_timer_bank_core NOT OK");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(0, 0, 300);
    test_random(65, 0, 300);
    test_random(0, 65, 300);
    test_random(33, 33, 300);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("tb_plc_timer_bank_core OK");
    end else begin
      $display("tb_plc_timer_bank_core NOT OK");
    end
    $finish;
  end

endmodule
